@@ rtl/dihedral_interval_vector_assert.svh @@
// Assertion macros for the dihedral interval vector block.
// Taken in by the top level; expects clk_i and rst_ni in scope.
`ifndef DIHEDRAL_INTERVAL_VECTOR_ASSERT_SVH
`define DIHEDRAL_INTERVAL_VECTOR_ASSERT_SVH

// same-cycle implication
`define DIV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DIV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/div_pkg.sv @@
// Shared types and constants for the dihedral interval vector block.
// No dependencies.
package div_pkg;

  localparam int IN_W       = 32;
  localparam int IDX_W      = 5;
  localparam int CNT_W      = 7;
  localparam int GRP_W      = 5;
  localparam int GRP_SIZE   = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0]  CFG_USE_RIGHT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  CFG_GROUP_ORDER = 1'b1;
  localparam logic [CFG_DATA_W-1:0] ORDER_RESET     = 6'd12;

  typedef struct packed {
    logic load;
    logic shift;
    logic shift_up;
  } cell_ctrl_t;

  typedef struct packed {
    logic a;
    logic b;
    logic x;
    logic y;
  } cell_bits_t;

  typedef struct packed {
    logic x;
    logic y;
  } mov_t;

  typedef struct packed {
    logic             coset;
    logic [IDX_W-1:0] idx;
    logic             last;
  } tag_t;

endpackage

@@ rtl/dihedral_interval_vector.sv @@
// Top level of the dihedral interval vector block.
// Uses div_pkg, div_cell, div_sum_tree and dihedral_interval_vector_assert.svh.
//
// Each accepted subset yields 2n results, one per cycle: rotation-coset entries
// 0..n-1, then reflection-coset entries 0..n-1, the last one with tlast set.
// The results (n = effective group order) are produced by the row of MAX_ORDER
// cells, which rotates its moving bits by one position per result; each result
// passes through the group-sum and count registers of the sum tree. A one-item
// input buffer takes the next subset while the current one is still streaming,
// so consecutive items follow without gaps. Output backpressure stalls the row.
`include "dihedral_interval_vector_assert.svh"

module dihedral_interval_vector #(
  parameter int MAX_ORDER = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [63:0]                     s_axis_tdata,  // rotation_mask, reflection_mask
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // entry_index, pair_count
  output logic                            m_axis_tuser,  // coset_select
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [div_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [div_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int M  = MAX_ORDER;
  localparam int IW = $clog2(M);
  localparam int NW = $clog2(M + 1);

  localparam logic PH_ROT = 1'b0;
  localparam logic PH_REF = 1'b1;

  // configuration
  logic                           use_right_q;
  logic [div_pkg::CFG_DATA_W-1:0] order_q;
  logic [NW-1:0]                  n_eff;
  logic [IW-1:0]                  nm1;
  logic [IW-1:0]                  sh;
  logic [M-1:0]                   mask_n;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_right_q <= 1'b0;
      order_q     <= div_pkg::ORDER_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        div_pkg::CFG_USE_RIGHT:   use_right_q <= cfg_data_i[0];
        div_pkg::CFG_GROUP_ORDER: order_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (order_q == '0) begin
      n_eff = NW'(1);
    end else if (order_q > div_pkg::CFG_DATA_W'(M)) begin
      n_eff = NW'(M);
    end else begin
      n_eff = NW'(order_q);
    end
  end

  assign nm1    = IW'(n_eff - NW'(1));
  assign sh     = IW'(NW'(M) - n_eff);
  assign mask_n = {M{1'b1}} >> sh;

  // input buffer
  logic         buf_valid_q, buf_valid_d;
  logic [M-1:0] buf_r_q, buf_f_q;
  logic         in_acc, take_buf;

  assign s_axis_tready = !buf_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign buf_valid_d   = (buf_valid_q && !take_buf) || in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
    end else begin
      buf_valid_q <= buf_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      buf_r_q <= s_axis_tdata[M-1:0] & mask_n;
      buf_f_q <= s_axis_tdata[div_pkg::IN_W +: M] & mask_n;
    end
  end

  // sequencer
  logic          busy_q, busy_d;
  logic          phase_q, phase_d;
  logic [IW-1:0] k_q, k_d;
  logic          adv, ld_rot, ld_ref, shift;
  logic [M-1:0]  cur_r_q, cur_f_q;
  logic          tree_valid;

  assign adv = !tree_valid || m_axis_tready;

  always_comb begin
    busy_d   = busy_q;
    phase_d  = phase_q;
    k_d      = k_q;
    ld_rot   = 1'b0;
    ld_ref   = 1'b0;
    shift    = 1'b0;
    take_buf = 1'b0;
    if (adv) begin
      if (busy_q) begin
        if (k_q == nm1) begin
          k_d = '0;
          if (phase_q == PH_ROT) begin
            ld_ref  = 1'b1;
            phase_d = PH_REF;
          end else if (buf_valid_q) begin
            ld_rot   = 1'b1;
            take_buf = 1'b1;
            phase_d  = PH_ROT;
          end else begin
            busy_d = 1'b0;
          end
        end else begin
          shift = 1'b1;
          k_d   = k_q + IW'(1);
        end
      end else if (buf_valid_q) begin
        ld_rot   = 1'b1;
        take_buf = 1'b1;
        busy_d   = 1'b1;
        phase_d  = PH_ROT;
        k_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PH_ROT;
      k_q     <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_rot) begin
      cur_r_q <= buf_r_q;
      cur_f_q <= buf_f_q;
    end
  end

  // index-reversed rotation mask: rev[i] = R[(n - i) mod n]
  logic [M-1:0] brev, rev_r;

  always_comb begin
    for (int i = 0; i < M; i++) begin
      brev[i] = cur_r_q[M-1-i];
    end
  end

  assign rev_r = (((brev >> sh) << 1) | M'(cur_r_q[0])) & mask_n;

  // cell row
  div_pkg::cell_ctrl_t ctrl;
  div_pkg::mov_t       mov [M];
  div_pkg::mov_t       mov_top;
  logic [M-1:0][1:0]   cell_val;

  assign ctrl.load     = ld_rot || ld_ref;
  assign ctrl.shift    = shift;
  assign ctrl.shift_up = !((phase_q == PH_REF) && !use_right_q);
  assign mov_top       = mov[nm1];

  for (genvar j = 0; j < M; j++) begin : g_cell
    localparam int UP = (j == M - 1) ? 0 : j + 1;
    localparam int DN = (j == 0) ? 0 : j - 1;
    div_pkg::cell_bits_t ld;
    div_pkg::mov_t       up_src, dn_src;

    always_comb begin
      if (ld_rot) begin
        ld.a = buf_r_q[j];
        ld.b = buf_f_q[j];
        ld.x = buf_r_q[j];
        ld.y = buf_f_q[j];
      end else if (use_right_q) begin
        ld.a = cur_r_q[j];
        ld.b = cur_r_q[j];
        ld.x = cur_f_q[j];
        ld.y = cur_f_q[j];
      end else begin
        ld.a = cur_f_q[j];
        ld.b = cur_f_q[j];
        ld.x = rev_r[j];
        ld.y = rev_r[j];
      end
    end

    assign up_src = (IW'(j) == nm1) ? mov[0] : mov[UP];
    assign dn_src = (j == 0) ? mov_top : mov[DN];

    div_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .load_i (ld),
      .up_i   (up_src),
      .dn_i   (dn_src),
      .mov_o  (mov[j]),
      .val_o  (cell_val[j])
    );
  end

  // sum and output
  div_pkg::tag_t             tag_in, tag_out;
  logic [div_pkg::CNT_W-1:0] count;

  assign tag_in.coset = phase_q;
  assign tag_in.idx   = div_pkg::IDX_W'(k_q);
  assign tag_in.last  = (phase_q == PH_REF) && (k_q == nm1);

  div_sum_tree #(
    .M (M)
  ) u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (busy_q),
    .tag_i   (tag_in),
    .val_i   (cell_val),
    .valid_o (tree_valid),
    .tag_o   (tag_out),
    .count_o (count)
  );

  assign m_axis_tvalid = tree_valid;
  assign m_axis_tdata  = {4'b0000, count, tag_out.idx};
  assign m_axis_tuser  = tag_out.coset;
  assign m_axis_tlast  = tag_out.last;

  logic [div_pkg::CNT_W-1:0] twice_n;
  assign twice_n = div_pkg::CNT_W'({n_eff, 1'b0});

  `DIV_ASSERT_NOW(a_last_at_end, m_axis_tvalid && m_axis_tlast, m_axis_tuser && (m_axis_tdata[4:0] == div_pkg::IDX_W'(nm1)), "last item not on final reflection entry")
  `DIV_ASSERT_NOW(a_count_bound, m_axis_tvalid, count <= twice_n, "pair count above 2n")
  `DIV_ASSERT_NOW(a_ref_even, m_axis_tvalid && m_axis_tuser, !count[0], "odd reflection-coset count")
  `DIV_ASSERT_NEXT(a_step_bound, busy_q, !busy_q || (k_q <= nm1), "entry counter past n-1")

endmodule

@@ rtl/div_cell.sv @@
// One cell of the correlation row: two fixed bits, two moving bits.
// Uses div_pkg for control and data structs.
module div_cell (
  input  logic                   clk_i,
  input  div_pkg::cell_ctrl_t    ctrl_i,
  input  div_pkg::cell_bits_t    load_i,
  input  div_pkg::mov_t          up_i,
  input  div_pkg::mov_t          dn_i,
  output div_pkg::mov_t          mov_o,
  output logic [1:0]             val_o
);

  logic a_q, b_q, x_q, y_q;
  logic a_d, b_d, x_d, y_d;

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    x_d = x_q;
    y_d = y_q;
    if (ctrl_i.load) begin
      a_d = load_i.a;
      b_d = load_i.b;
      x_d = load_i.x;
      y_d = load_i.y;
    end else if (ctrl_i.shift) begin
      x_d = ctrl_i.shift_up ? up_i.x : dn_i.x;
      y_d = ctrl_i.shift_up ? up_i.y : dn_i.y;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    x_q <= x_d;
    y_q <= y_d;
  end

  assign mov_o.x = x_q;
  assign mov_o.y = y_q;
  assign val_o   = {1'b0, a_q & x_q} + {1'b0, b_q & y_q};

endmodule

@@ rtl/div_sum_tree.sv @@
// Two-stage registered sum of the cell products, carrying the result tag.
// Uses div_pkg for tag type and widths.
module div_sum_tree #(
  parameter int M = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  div_pkg::tag_t              tag_i,
  input  logic [M-1:0][1:0]          val_i,
  output logic                       valid_o,
  output div_pkg::tag_t              tag_o,
  output logic [div_pkg::CNT_W-1:0]  count_o
);

  localparam int G = (M + div_pkg::GRP_SIZE - 1) / div_pkg::GRP_SIZE;

  logic [G-1:0][div_pkg::GRP_W-1:0] grp_d, grp_q;
  logic                             a_valid_q, b_valid_q;
  div_pkg::tag_t                    a_tag_q, b_tag_q;
  logic [div_pkg::CNT_W-1:0]        count_d, count_q;

  always_comb begin
    for (int g = 0; g < G; g++) begin
      grp_d[g] = '0;
      for (int e = 0; e < div_pkg::GRP_SIZE; e++) begin
        if (g * div_pkg::GRP_SIZE + e < M) begin
          grp_d[g] = grp_d[g] + div_pkg::GRP_W'(val_i[g * div_pkg::GRP_SIZE + e]);
        end
      end
    end
  end

  always_comb begin
    count_d = '0;
    for (int g = 0; g < G; g++) begin
      count_d = count_d + div_pkg::CNT_W'(grp_q[g]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_q   <= grp_d;
      a_tag_q <= tag_i;
      count_q <= count_d;
      b_tag_q <= a_tag_q;
    end
  end

  assign valid_o = b_valid_q;
  assign tag_o   = b_tag_q;
  assign count_o = count_q;

endmodule

@@ tb/tb_dihedral_interval_vector.sv @@
// Self-checking testbench for dihedral_interval_vector: random and directed subsets of D_2n,
// left and right interval vectors, predicted per item and compared entry by entry.
// Depends on div_pkg and the dihedral_interval_vector RTL only.
`timescale 1ns / 100ps

module tb_dihedral_interval_vector;

  localparam int ORDER_CAP     = 32;
  localparam int NUM_PHASES    = 14;
  localparam int PHASE_ITEMS   = 24;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 400;
  localparam bit COSET_ROT     = 1'b0;
  localparam bit COSET_REFL    = 1'b1;

  typedef struct {
    bit       coset;
    bit [4:0] idx;
    bit [6:0] cnt;
    bit       last;
  } entry_t;

  class interval_scoreboard;
    bit       right_vec;
    bit [5:0] order_reg;
    entry_t   entry_q[$];
    int       subsets;
    int       entries;
    int       mismatches;

    function new();
      right_vec = 1'b0;
      order_reg = div_pkg::ORDER_RESET;
    endfunction

    function void set_reg(logic [div_pkg::CFG_IDX_W-1:0] idx,
                          logic [div_pkg::CFG_DATA_W-1:0] value);
      if (idx == div_pkg::CFG_USE_RIGHT) right_vec = value[0];
      else if (idx == div_pkg::CFG_GROUP_ORDER) order_reg = value;
    endfunction

    function int pending();
      return entry_q.size();
    endfunction

    function void log_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void note_subset(bit [31:0] rot, bit [31:0] refl);
      int       n;
      int       dij;
      int       dji;
      bit [6:0] rot_cnt[ORDER_CAP];
      bit [6:0] refl_cnt[ORDER_CAP];
      entry_t   e;
      n = (order_reg == 0) ? 1 : ((order_reg > ORDER_CAP) ? ORDER_CAP : int'(order_reg));
      for (int k = 0; k < ORDER_CAP; k++) begin
        rot_cnt[k]  = '0;
        refl_cnt[k] = '0;
      end
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          dij = (i + n - j) % n;
          dji = (j + n - i) % n;
          if (!right_vec) begin
            rot_cnt[dij] += 7'(rot[i] & rot[j]) + 7'(refl[i] & refl[j]);
            refl_cnt[(i + j) % n] += 7'(refl[i] & rot[j]) + 7'(rot[i] & refl[j]);
          end else begin
            rot_cnt[dji]  += 7'(rot[i] & rot[j]);
            rot_cnt[dij]  += 7'(refl[i] & refl[j]);
            refl_cnt[dji] += 7'(rot[i] & refl[j]);
            refl_cnt[dij] += 7'(refl[i] & rot[j]);
          end
        end
      end
      for (int k = 0; k < 2 * n; k++) begin
        e.coset = (k < n) ? COSET_ROT : COSET_REFL;
        e.idx   = 5'((k < n) ? k : k - n);
        e.cnt   = (k < n) ? rot_cnt[k] : refl_cnt[k - n];
        e.last  = (k == 2 * n - 1);
        entry_q.push_back(e);
      end
      subsets++;
    endfunction

    function void check_result(logic coset, logic [4:0] idx, logic [6:0] cnt, logic last);
      entry_t want;
      if (entry_q.size() == 0) begin
        log_error($sformatf("unexpected entry coset %0d idx %0d count %0d last %0d",
                            coset, idx, cnt, last));
        return;
      end
      want = entry_q.pop_front();
      entries++;
      if (coset !== want.coset || idx !== want.idx || cnt !== want.cnt || last !== want.last)
        log_error($sformatf("expected coset %0d idx %0d count %0d last %0d, got %0d %0d %0d %0d",
                            want.coset, want.idx, want.cnt, want.last, coset, idx, cnt, last));
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [63:0]                    s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [15:0]                    m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           m_axis_tlast;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [div_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [div_pkg::CFG_DATA_W-1:0] cfg_data_i;

  interval_scoreboard sb;
  bit tx_quiet;
  bit rx_quiet;
  int hold_req;
  int settings_run;
  logic [5:0] order_plan [NUM_PHASES] = '{6'd1, 6'd2, 6'd32, 6'd3, 6'd5, 6'd7, 6'd0,
                                          6'd12, 6'd4, 6'd63, 6'd16, 6'd9, 6'd33, 6'd31};

  dihedral_interval_vector #(.MAX_ORDER(ORDER_CAP)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic bit [31:0] random_mask();
    case ($urandom_range(0, 5))
      3: return $urandom & $urandom & $urandom;
      4: return $urandom | $urandom | $urandom;
      5: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return '1;
          default: return 32'd1 << $urandom_range(0, 31);
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_subset(bit [31:0] rot, bit [31:0] refl);
    int gap;
    gap = draw_gap(tx_quiet);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {refl, rot};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_subset(rot, refl);
  endtask

  task automatic write_reg(logic [div_pkg::CFG_IDX_W-1:0] idx,
                           logic [div_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(bit right_sel, logic [5:0] order);
    drain();
    write_reg(div_pkg::CFG_USE_RIGHT, {5'd0, right_sel});
    write_reg(div_pkg::CFG_GROUP_ORDER, order);
    settings_run++;
  endtask

  // receiver: random stalls per result, plus a long hold-off on request
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = (hold_req > 0) ? hold_req : draw_gap(rx_quiet);
      hold_req = 0;
      if (gap > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[11:5], m_axis_tlast);
  end

  initial begin
    #2500000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    sb            = new();
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    hold_req      = 0;
    settings_run  = 1;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = div_pkg::CFG_USE_RIGHT;
    cfg_data_i    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: left vector, n = 12
    send_subset(32'h0000_0000, 32'h0000_0000);
    send_subset(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_subset(32'hFFFF_FFFF, 32'h0000_0000);
    send_subset(32'h0000_0000, 32'hFFFF_FFFF);
    send_subset(32'h0000_0001, 32'h0000_0000);
    send_subset(32'h0000_0000, 32'h0000_0001);
    send_subset(32'h0000_0800, 32'h0000_0800);
    send_subset(32'hFFFF_F000, 32'hFFFF_F000);
    send_subset(32'h0000_0555, 32'h0000_0AAA);
    send_subset(32'h0000_0091, 32'h0000_0010);

    set_mode(1'b1, 6'd32);
    send_subset(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_subset(32'h8000_0000, 32'h0000_0001);
    send_subset(32'h0000_0001, 32'h8000_0000);
    send_subset(32'hAAAA_AAAA, 32'h5555_5555);
    send_subset(32'h1234_5678, 32'h0000_0000);

    // group order zero acts as one, bits above it are dropped; order 63 is clamped to 32
    set_mode(1'b1, 6'd0);
    send_subset(32'h0000_0001, 32'h0000_0001);
    send_subset(32'hFFFF_FFFE, 32'hFFFF_FFFE);
    set_mode(1'b0, 6'd63);
    send_subset(32'hC000_0003, 32'h8001_0001);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_mode((p < 2) ? p[0] : 1'($urandom_range(0, 1)), order_plan[p]);
      tx_quiet = (p % 4 == 1);
      rx_quiet = tx_quiet;
      if (p == 4) begin
        tx_quiet = 1'b1;
        hold_req = HOLD_CYCLES;
      end
      repeat (PHASE_ITEMS) send_subset(random_mask(), random_mask());
    end
    drain();

    $display("Covered %0d subsets under %0d register settings, %0d entries compared.",
             sb.subsets, settings_run, sb.entries);
    $display("Mismatches: %0d, entries still outstanding: %0d.", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ dihedral_interval_vector.f @@
+incdir+rtl
rtl/div_pkg.sv
rtl/div_cell.sv
rtl/div_sum_tree.sv
rtl/dihedral_interval_vector.sv
tb/tb_dihedral_interval_vector.sv
